// ----- hw/rtl/obc_pkg.sv -----
// ----------------------------------------------------------------------------
// obc_pkg
// Shared widths and limits for the basis completion block.
// ----------------------------------------------------------------------------
package obc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COMP_WIDTH_DEF = 24;
    localparam int IN_LIM = 26;
    localparam int UNIT_LIM = 30;

    // reduced vectors below 2^30 -> 31-bit signed; squares sum below 2^62
    localparam int UW = UNIT_LIM + 1;
    localparam int SSW = 2 * UNIT_LIM + 2;
    localparam int LW = UNIT_LIM + 1;

endpackage

// ----- hw/rtl/obc_reduce.sv -----
// ----------------------------------------------------------------------------
// obc_reduce
// Common right shift of three signed magnitudes until all lie below 2^LIM.
// Registered output.
// ----------------------------------------------------------------------------
module obc_reduce #(
    parameter int IW  = 64,
    parameter int LIM = 30
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [IW-1:0] i_v [3],
    output logic signed [LIM:0]  o_v [3]
);
    localparam int SHW = $clog2(IW + 1);
    localparam int QW  = (IW > LIM) ? IW : LIM;

    logic [IW-1:0] m [3];
    logic [IW-1:0] mx;
    logic [SHW-1:0] sh;
    logic signed [LIM:0] n_v [3];
    logic signed [LIM:0] r_v [3];
    logic [QW-1:0] q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m[i] = i_v[i][IW-1] ? IW'(-i_v[i]) : IW'(i_v[i]);
        end
        mx = m[0] | m[1] | m[2];
        sh = '0;
        for (int b = LIM; b < IW; b++) begin
            if (mx[b]) begin
                sh = SHW'(b - LIM + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            q = QW'(m[i]) >> sh;
            n_v[i] = i_v[i][IW-1] ? -$signed({1'b0, q[LIM-1:0]})
                                  : $signed({1'b0, q[LIM-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;
endmodule

// ----- hw/rtl/obc_unit.sv -----
// ----------------------------------------------------------------------------
// obc_unit
// Pipelined unit vector: reduce, sum of squares, digit-pipelined square root,
// restoring division per component with rounding.
// ----------------------------------------------------------------------------
module obc_unit #(
    parameter int IW   = 64,
    parameter int FRAC = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [IW-1:0] i_v [3],
    output logic signed [FRAC+1:0] o_u [3]
);
    import obc_pkg::*;

    localparam int NW = UNIT_LIM + FRAC;   // dividend width
    localparam int DS = NW + 1;            // divide steps

    logic signed [UNIT_LIM:0] w [3];

    obc_reduce #(.IW(IW), .LIM(UNIT_LIM)) u_red (
        .i_clk(i_clk), .i_en(i_en), .i_v(i_v), .o_v(w)
    );

    // squares
    logic [UNIT_LIM-1:0] r_m [3];
    logic [2:0] r_s0;
    logic [SSW-1:0] r_sq [3];
    logic [UNIT_LIM-1:0] r_m1 [3];
    logic [2:0] r_s1;
    logic [SSW-1:0] r_ss;
    logic [UNIT_LIM-1:0] r_m2 [3];
    logic [2:0] r_s2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]  <= w[i][UNIT_LIM] ? UNIT_LIM'(-w[i]) : UNIT_LIM'(w[i]);
                r_s0[i] <= w[i][UNIT_LIM];
            end
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SSW'(r_m[i]) * SSW'(r_m[i]);
            end
            r_m1 <= r_m;
            r_s1 <= r_s0;
            r_ss <= r_sq[0] + r_sq[1] + r_sq[2];
            r_m2 <= r_m1;
            r_s2 <= r_s1;
        end
    end

    // square root, one result bit per stage
    logic [SSW-1:0] sq_rem [LW+1];
    logic [LW-1:0]  sq_root [LW+1];
    logic [UNIT_LIM-1:0] sq_m [LW+1][3];
    logic [2:0] sq_s [LW+1];

    assign sq_rem[0] = r_ss;
    assign sq_root[0] = '0;
    assign sq_m[0] = r_m2;
    assign sq_s[0] = r_s2;

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        localparam int B = LW - 1 - k;
        logic [SSW+1:0] trial;
        logic [SSW-1:0] r_rem;
        logic [LW-1:0] r_root;
        logic [UNIT_LIM-1:0] r_mk [3];
        logic [2:0] r_sk;
        always_comb begin
            trial = ((SSW+2)'(sq_root[k]) << (B + 1)) + ((SSW+2)'(1) << (2 * B));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((SSW+2)'(sq_rem[k]) >= trial) begin
                    r_rem  <= SSW'((SSW+2)'(sq_rem[k]) - trial);
                    r_root <= sq_root[k] | (LW'(1) << B);
                end else begin
                    r_rem  <= sq_rem[k];
                    r_root <= sq_root[k];
                end
                r_mk <= sq_m[k];
                r_sk <= sq_s[k];
            end
        end
        assign sq_rem[k+1] = r_rem;
        assign sq_root[k+1] = r_root;
        assign sq_m[k+1] = r_mk;
        assign sq_s[k+1] = r_sk;
    end

    // dividend prep: (m << FRAC) + len/2, divisor len (min 1)
    logic [NW:0] r_nd [3];
    logic [LW-1:0] r_len;
    logic [2:0] r_s3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= (sq_root[LW] == '0) ? LW'(1) : sq_root[LW];
            for (int i = 0; i < 3; i++) begin
                r_nd[i] <= ((NW+1)'(sq_m[LW][i]) << FRAC)
                         + (NW+1)'(((sq_root[LW] == '0) ? LW'(1) : sq_root[LW]) >> 1);
            end
            r_s3 <= sq_s[LW];
        end
    end

    // restoring division, one quotient bit per stage
    logic [NW:0] dv_n [DS+1][3];
    logic [LW:0] dv_r [DS+1][3];
    logic [FRAC+1:0] dv_q [DS+1][3];
    logic [LW-1:0] dv_d [DS+1];
    logic [2:0] dv_s [DS+1];

    assign dv_n[0] = r_nd;
    assign dv_d[0] = r_len;
    assign dv_s[0] = r_s3;
    for (genvar i = 0; i < 3; i++) begin : g_d0
        assign dv_r[0][i] = '0;
        assign dv_q[0][i] = '0;
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        localparam int B = DS - 1 - k;
        logic [NW:0] r_n [3];
        logic [LW:0] r_r [3];
        logic [FRAC+1:0] r_q [3];
        logic [LW-1:0] r_d;
        logic [2:0] r_sk;
        logic [LW+1:0] t [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i] = {dv_r[k][i], dv_n[k][i][B]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (t[i] >= (LW+2)'(dv_d[k])) begin
                        r_r[i] <= (LW+1)'(t[i] - (LW+2)'(dv_d[k]));
                        r_q[i] <= (FRAC+2)'({dv_q[k][i], 1'b1});
                    end else begin
                        r_r[i] <= (LW+1)'(t[i]);
                        r_q[i] <= (FRAC+2)'({dv_q[k][i], 1'b0});
                    end
                end
                r_n <= dv_n[k];
                r_d <= dv_d[k];
                r_sk <= dv_s[k];
            end
        end
        assign dv_n[k+1] = r_n;
        assign dv_r[k+1] = r_r;
        assign dv_q[k+1] = r_q;
        assign dv_d[k+1] = r_d;
        assign dv_s[k+1] = r_sk;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_u[i] = dv_s[DS][i] ? -$signed(dv_q[DS][i]) : $signed(dv_q[DS][i]);
        end
    end
endmodule

// ----- hw/rtl/orthonormal_basis_completion.sv -----
// ----------------------------------------------------------------------------
// orthonormal_basis_completion
// Completes an orthonormal basis from one 3D vector (cross products, fixed point).
// ----------------------------------------------------------------------------
// channel | dir | valid   | stall   | fields
// input   | in  | i_valid | o_stall | i_in_x, i_in_y, i_in_z
// result  | out | o_valid | i_stall | o_first_*, o_second_*, o_degenerate
//
// One beat per cycle while not stalled. Stages: input reduce, cross products,
// then the unit-vector pipe (square root one bit per stage, divide one bit
// per stage); 86 stages at default widths.
// The whole pipe advances together; an output stall freezes it, and input
// stall follows the output stall. Reset clears valid bits only.
// ----------------------------------------------------------------------------
module orthonormal_basis_completion
    import obc_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_in_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_in_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_in_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [FRAC_BITS+1:0]       o_first_x,
    output logic signed [FRAC_BITS+1:0]       o_first_y,
    output logic signed [FRAC_BITS+1:0]       o_first_z,
    output logic signed [FRAC_BITS+1:0]       o_second_x,
    output logic signed [FRAC_BITS+1:0]       o_second_y,
    output logic signed [FRAC_BITS+1:0]       o_second_z,
    output logic                              o_degenerate
);
    localparam int AW = IN_LIM + 1;      // reduced input
    localparam int CW = AW + 3;          // c components
    localparam int RW = AW + CW + 2;     // r2 components
    localparam int PW = AW + CW;         // c * a products
    localparam int UL = 1 + 3 + LW + 1 + (UNIT_LIM + FRAC_BITS + 1);
    localparam int LAT = 3 + UL;
    localparam int OW = FRAC_BITS + 2;

    logic en;
    logic [LAT-1:0] r_vld;

    // pipe stalls only when the last stage holds a beat that is not taken
    assign en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage 1: zero check, reduce
    logic signed [COMPONENT_WIDTH-1:0] in_v [3];
    logic signed [IN_LIM:0] a [3];
    logic r_z1;

    assign in_v[0] = i_in_x;
    assign in_v[1] = i_in_y;
    assign in_v[2] = i_in_z;

    obc_reduce #(.IW(COMPONENT_WIDTH), .LIM(IN_LIM)) u_red_in (
        .i_clk(i_clk), .i_en(en), .i_v(in_v), .o_v(a)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z1 <= (i_in_x == '0) && (i_in_y == '0) && (i_in_z == '0);
        end
    end

    // stage 2: c and t
    logic signed [CW-1:0] r_c [3];
    logic signed [AW-1:0] r_a2 [3];
    logic r_dg2;
    logic r_tn2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [CW-1:0] ax, ay, az, c0, c1, c2, t;
            ax = CW'(a[0]);
            ay = CW'(a[1]);
            az = CW'(a[2]);
            c0 = CW'(2 * az - 3 * ay);
            c1 = CW'(3 * ax - az);
            c2 = CW'(ay - 2 * ax);
            t  = CW'(2 * ay - ax - az);
            r_c[0] <= c0;
            r_c[1] <= c1;
            r_c[2] <= c2;
            r_a2 <= a;
            r_dg2 <= r_z1 || (c0 == '0 && c1 == '0 && c2 == '0) || (t == '0);
            r_tn2 <= t[CW-1];
        end
    end

    // stage 3: r2 = c x a
    logic signed [RW-1:0] r_r2 [3];
    logic signed [RW-1:0] c_ext [3];
    logic signed [PW-1:0] p [6];
    logic r_dg3, r_tn3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_ext[i] = RW'(r_c[i]);
        end
        p[0] = r_c[1] * r_a2[2];
        p[1] = r_c[2] * r_a2[1];
        p[2] = r_c[2] * r_a2[0];
        p[3] = r_c[0] * r_a2[2];
        p[4] = r_c[0] * r_a2[1];
        p[5] = r_c[1] * r_a2[0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2[0] <= RW'(p[0]) - RW'(p[1]);
            r_r2[1] <= RW'(p[2]) - RW'(p[3]);
            r_r2[2] <= RW'(p[4]) - RW'(p[5]);
            r_dg3 <= r_dg2;
            r_tn3 <= r_tn2;
        end
    end

    logic signed [OW-1:0] f [3];
    logic signed [OW-1:0] g [3];

    obc_unit #(.IW(RW), .FRAC(FRAC_BITS)) u_unit_f (
        .i_clk(i_clk), .i_en(en), .i_v(r_r2), .o_u(f)
    );
    obc_unit #(.IW(RW), .FRAC(FRAC_BITS)) u_unit_g (
        .i_clk(i_clk), .i_en(en), .i_v(c_ext), .o_u(g)
    );

    // c is not delayed, so the g unit sees c one stage earlier than the f unit
    // sees r2; a register on the g output (r_g) realigns the two.
    logic signed [OW-1:0] r_g [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g <= g;
        end
    end

    logic [UL-1:0] r_dgp, r_tnp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dgp <= {r_dgp[UL-2:0], r_dg3};
            r_tnp <= {r_tnp[UL-2:0], r_tn3};
        end
    end

    logic dg;
    assign dg = r_dgp[UL-1];
    assign o_valid = r_vld[LAT-1];
    assign o_degenerate = dg;
    assign o_first_x  = dg ? '0 : f[0];
    assign o_first_y  = dg ? '0 : f[1];
    assign o_first_z  = dg ? '0 : f[2];
    assign o_second_x = dg ? '0 : (r_tnp[UL-1] ? -r_g[0] : r_g[0]);
    assign o_second_y = dg ? '0 : (r_tnp[UL-1] ? -r_g[1] : r_g[1]);
    assign o_second_z = dg ? '0 : (r_tnp[UL-1] ? -r_g[2] : r_g[2]);
endmodule

// ----- bench/orthonormal_basis_completion_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orthonormal_basis_completion_tb
// Drives input vectors through the basis completion block under varying
// sender gaps and receiver stalls, predicts each result with an integer model
// of the cross-product forms and checks every output beat in order.
// ----------------------------------------------------------------------------
module orthonormal_basis_completion_tb;
    import obc_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int CW = COMP_WIDTH_DEF;
    localparam int OW = FB + 2;

    typedef struct packed {
        logic signed [OW-1:0] fx, fy, fz, sx, sy, sz;
        logic                 degen;
    } basis_t;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic signed [CW-1:0] i_in_x = 0, i_in_y = 0, i_in_z = 0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic signed [OW-1:0] o_first_x, o_first_y, o_first_z;
    logic signed [OW-1:0] o_second_x, o_second_y, o_second_z;
    logic                 o_degenerate;

    basis_t basis_q[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 0;

    orthonormal_basis_completion dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void shrink(ref longint v[3], input int lim);
        longint mx;
        int     s;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
        while (s < 63 && (mx >> s) >= (64'd1 << lim)) s++;
        for (int i = 0; i < 3; i++)
            v[i] = v[i] < 0 ? -(mag(v[i]) >> s) : (mag(v[i]) >> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void normalize(input longint v[3], output longint u[3]);
        longint          w[3];
        longint unsigned ss, len, q;
        w = v;
        shrink(w, UNIT_LIM);
        ss = 0;
        for (int i = 0; i < 3; i++) ss += mag(w[i]) * mag(w[i]);
        len = int_sqrt(ss);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag(w[i]) << FB) + (len >> 1)) / len;
            u[i] = w[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic basis_t complete_basis(logic signed [CW-1:0] x, y, z);
        longint a[3], c[3], r[3], f[3], g[3], t;
        basis_t b;
        a = '{x, y, z};
        f = '{0, 0, 0};
        g = '{0, 0, 0};
        b.degen = 0;
        if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
            b.degen = 1;
        end else begin
            shrink(a, IN_LIM);
            c[0] = 2 * a[2] - 3 * a[1];
            c[1] = 3 * a[0] - a[2];
            c[2] = a[1] - 2 * a[0];
            t = 2 * a[1] - a[0] - a[2];
            if ((c[0] == 0 && c[1] == 0 && c[2] == 0) || t == 0) begin
                b.degen = 1;
            end else begin
                r[0] = c[1] * a[2] - c[2] * a[1];
                r[1] = c[2] * a[0] - c[0] * a[2];
                r[2] = c[0] * a[1] - c[1] * a[0];
                normalize(r, f);
                normalize(c, g);
                if (t < 0) for (int i = 0; i < 3; i++) g[i] = -g[i];
            end
        end
        b.fx = OW'(f[0]); b.fy = OW'(f[1]); b.fz = OW'(f[2]);
        b.sx = OW'(g[0]); b.sy = OW'(g[1]); b.sz = OW'(g[2]);
        return b;
    endfunction

    // receiver: random stalls, or a long hold-off
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        basis_t e, a;
        if (i_rst_n && o_valid && !i_stall) begin
            a = '{o_first_x, o_first_y, o_first_z, o_second_x, o_second_y,
                  o_second_z, o_degenerate};
            if (basis_q.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = basis_q.pop_front();
                if (a.fx !== e.fx) begin $error("first_x exp %0d got %0d", e.fx, a.fx); errors++; end
                if (a.fy !== e.fy) begin $error("first_y exp %0d got %0d", e.fy, a.fy); errors++; end
                if (a.fz !== e.fz) begin $error("first_z exp %0d got %0d", e.fz, a.fz); errors++; end
                if (a.sx !== e.sx) begin $error("second_x exp %0d got %0d", e.sx, a.sx); errors++; end
                if (a.sy !== e.sy) begin $error("second_y exp %0d got %0d", e.sy, a.sy); errors++; end
                if (a.sz !== e.sz) begin $error("second_z exp %0d got %0d", e.sz, a.sz); errors++; end
                if (a.degen !== e.degen) begin
                    $error("degenerate exp %0d got %0d", e.degen, a.degen);
                    errors++;
                end
            end
        end
    end

    task automatic send_vector(logic signed [CW-1:0] x, y, z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        basis_q.push_back(complete_basis(x, y, z));
    endtask

    task automatic go_idle();
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (basis_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(4))
            0: return CW'($urandom_range(255) - 128);
            1: return $urandom_range(1, 0) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            2: return CW'($urandom_range(1 << 18) - (1 << 17));
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_vector(0, 0, 0);
        send_vector(1, 2, 3);
        send_vector(-1000, -2000, -3000);
        send_vector(1, 1, 1);
        send_vector(1, 0, 1);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mx, mn, mx);
        send_vector(mn, mx, mn);
        send_vector(mx, 0, 0);
        send_vector(0, mn, 0);
        send_vector(0, 0, mx);
        send_vector(1, 0, 0);
        send_vector(0, -1, 0);
        send_vector(0, 0, 1);
        send_vector(-1, 0, 0);
        send_vector(65536, 0, 0);
        send_vector(mx, CW'(mx - 1), mn);
        send_vector(-1, -1, -1);
        send_vector(2796202, 5592404, 8388606);
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        logic signed [CW-1:0] x, y, z;
        int k;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            k = $urandom_range(19);
            if (k == 0) begin
                k = $urandom_range(1 << 20) - (1 << 19);
                send_vector(CW'(k), CW'(2 * k), CW'(3 * k));
            end else if (k == 1) begin
                send_vector(x, y, CW'(2 * y - x));
            end else begin
                send_vector(x, y, z);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        int held;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        fork
            begin
                held = 0;
                while (held < 200) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++)
                send_vector(CW'($urandom), CW'($urandom), CW'($urandom));
        join
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 73, 0);
        test_random(300, 0, 73);
        test_random(300, 32, 32);
        test_backpressure();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && basis_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
